[src/obm_pkg.sv]
// ----------------------------------------------------------------------------
// obm_pkg
// Shared types, codes and defaults of the limit order book matcher.
// ----------------------------------------------------------------------------
package obm_pkg;

  // Default number of resting order slots.
  localparam int ORDER_SLOTS_DEF = 32;

  // Command codes.
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  // Side codes.
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // Result kinds.
  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DECIDE,
    ST_REST,
    ST_OUT
  } obm_state_t;

  // One input item.
  typedef struct packed {
    logic        cmd;
    logic [31:0] order_ident;
    logic        side;
    logic [31:0] limit_price;
    logic [31:0] quantity_in;
  } obm_in_item_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [31:0] buy_ident;
    logic [31:0] sell_ident;
    logic [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic        rested;
    logic        book_full;
    logic        cancelled;
    logic        last;
  } obm_out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic scan_start;
    logic scan_step;
    logic fill;
    logic cancel_done;
    logic rest;
  } obm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_cancel;
    logic add_done;
    logic found;
    logic scan_last;
    logic out_last;
  } obm_sts_t;

endpackage

[src/obm_if.sv]
// ----------------------------------------------------------------------------
// obm_if
// Valid/ready channels carrying order commands in and results out.
// ----------------------------------------------------------------------------
interface obm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] order_ident;
  logic        side;
  logic [31:0] limit_price;
  logic [31:0] quantity_in;

  modport source (output valid, cmd, order_ident, side, limit_price, quantity_in,
                  input ready);
  modport sink (input valid, cmd, order_ident, side, limit_price, quantity_in,
                output ready);
endinterface

interface obm_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] buy_ident;
  logic [31:0] sell_ident;
  logic [31:0] trade_price;
  logic [31:0] trade_quantity;
  logic        rested;
  logic        book_full;
  logic        cancelled;
  logic        last;

  modport source (output valid, kind, buy_ident, sell_ident, trade_price,
                  trade_quantity, rested, book_full, cancelled, last,
                  input ready);
  modport sink (input valid, kind, buy_ident, sell_ident, trade_price,
                trade_quantity, rested, book_full, cancelled, last,
                output ready);
endinterface

[src/obm_ctrl.sv]
// ----------------------------------------------------------------------------
// obm_ctrl
// Controller state machine: sequences scans, fills, resting and output.
// ----------------------------------------------------------------------------
module obm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  obm_pkg::obm_sts_t sts,
  output obm_pkg::obm_cmd_t cmd
);
  import obm_pkg::*;

  obm_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_START;
      end
      ST_START: begin
        if (!sts.is_cancel && sts.add_done) state_nxt = ST_REST;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.is_cancel || sts.found) state_nxt = ST_OUT;
        else state_nxt = ST_REST;
      end
      ST_REST: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_nxt = sts.out_last ? ST_IDLE : ST_START;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_START: cmd.scan_start = 1'b1;
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_DECIDE: begin
        cmd.cancel_done = sts.is_cancel;
        cmd.fill        = !sts.is_cancel && sts.found;
      end
      ST_REST: cmd.rest = 1'b1;
      ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  // An accepted item keeps the input closed until its results are out.
  a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("input stayed open");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input open while result pending");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && sts.out_last) |=> in_ready)
    else $error("status record did not end the command");

endmodule

[src/obm_dp.sv]
// ----------------------------------------------------------------------------
// obm_dp
// Datapath: slot table, best-order scan, fill arithmetic and result register.
// ----------------------------------------------------------------------------
module obm_dp #(
  parameter int ORDER_SLOTS = obm_pkg::ORDER_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  obm_pkg::obm_in_item_t  in_item,
  input  obm_pkg::obm_cmd_t      cmd,
  output obm_pkg::obm_sts_t      sts,
  output obm_pkg::obm_out_item_t out_item
);
  import obm_pkg::*;

  localparam int IDX_W = $clog2(ORDER_SLOTS);
  localparam int CNT_W = $clog2(ORDER_SLOTS + 1);

  // Slot table.
  logic [ORDER_SLOTS-1:0] valid_r;
  logic [31:0]            ident_r  [ORDER_SLOTS];
  logic                   side_r   [ORDER_SLOTS];
  logic [31:0]            price_r  [ORDER_SLOTS];
  logic [31:0]            volume_r [ORDER_SLOTS];
  logic [63:0]            stamp_r  [ORDER_SLOTS];
  logic [63:0]            arrival_r;

  // Current command.
  logic        c_cancel_r, c_side_r;
  logic [31:0] c_ident_r, c_limit_r, c_vol_r;
  logic [CNT_W-1:0] n_r;

  // Scan state and best candidate.
  logic [IDX_W-1:0] idx_r;
  logic             found_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [31:0]      best_ident_r, best_price_r, best_vol_r;
  logic [63:0]      best_stamp_r;

  obm_out_item_t out_r, out_nxt;

  // Candidate test on the slot under the scan pointer.
  logic        rd_valid, rd_side, qual, better;
  logic [31:0] rd_ident, rd_price;
  logic [63:0] rd_stamp;
  always_comb begin
    rd_valid = valid_r[idx_r];
    rd_side  = side_r[idx_r];
    rd_ident = ident_r[idx_r];
    rd_price = price_r[idx_r];
    rd_stamp = stamp_r[idx_r];
    if (c_cancel_r) begin
      qual   = rd_valid && (rd_ident == c_ident_r);
      better = !found_r || (rd_stamp < best_stamp_r);
    end else begin
      qual = rd_valid && (rd_side != c_side_r) &&
             ((c_side_r == SIDE_BUY) ? (rd_price <= c_limit_r) : (rd_price >= c_limit_r));
      if (!found_r) better = 1'b1;
      else if (rd_price != best_price_r)
        better = (c_side_r == SIDE_BUY) ? (rd_price < best_price_r)
                                        : (rd_price > best_price_r);
      else better = rd_stamp < best_stamp_r;
    end
  end

  // Fill amount and lowest free slot.
  logic [31:0]      fill;
  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    fill     = (c_vol_r < best_vol_r) ? c_vol_r : best_vol_r;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Next result item: a trade on a fill, a status record ending the command.
  always_comb begin
    out_nxt = out_r;
    if (cmd.fill) begin
      out_nxt                = '0;
      out_nxt.kind           = KIND_TRADE;
      out_nxt.buy_ident      = (c_side_r == SIDE_BUY) ? c_ident_r : best_ident_r;
      out_nxt.sell_ident     = (c_side_r == SIDE_BUY) ? best_ident_r : c_ident_r;
      out_nxt.trade_price    = best_price_r;
      out_nxt.trade_quantity = fill;
    end
    if (cmd.cancel_done) begin
      out_nxt           = '0;
      out_nxt.kind      = KIND_STATUS;
      out_nxt.cancelled = found_r;
      out_nxt.last      = 1'b1;
    end
    if (cmd.rest) begin
      out_nxt           = '0;
      out_nxt.kind      = KIND_STATUS;
      out_nxt.rested    = (c_vol_r != '0) && free_any;
      out_nxt.book_full = (c_vol_r != '0) && !free_any;
      out_nxt.last      = 1'b1;
    end
  end

  // Control registers: valid bits, arrival counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      arrival_r <= '0;
    end else begin
      if (cmd.cancel_done && found_r) valid_r[best_idx_r] <= 1'b0;
      if (cmd.fill && (best_vol_r == fill)) valid_r[best_idx_r] <= 1'b0;
      if (cmd.rest && (c_vol_r != '0) && free_any) begin
        valid_r[free_idx] <= 1'b1;
        arrival_r         <= arrival_r + 64'd1;
      end
    end
  end

  // Slot payload writes.
  always_ff @(posedge clk) begin
    if (cmd.fill) volume_r[best_idx_r] <= best_vol_r - fill;
    if (cmd.rest && (c_vol_r != '0) && free_any) begin
      ident_r[free_idx]  <= c_ident_r;
      side_r[free_idx]   <= c_side_r;
      price_r[free_idx]  <= c_limit_r;
      volume_r[free_idx] <= c_vol_r;
      stamp_r[free_idx]  <= arrival_r;
    end
  end

  // Command latch, scan and result register.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      c_cancel_r <= in_item.cmd;
      c_side_r   <= in_item.side;
      c_ident_r  <= in_item.order_ident;
      c_limit_r  <= in_item.limit_price;
      c_vol_r    <= in_item.quantity_in;
      n_r        <= '0;
    end
    if (cmd.scan_start) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (qual && better) begin
        found_r      <= 1'b1;
        best_idx_r   <= idx_r;
        best_ident_r <= rd_ident;
        best_price_r <= rd_price;
        best_vol_r   <= volume_r[idx_r];
        best_stamp_r <= rd_stamp;
      end
    end
    if (cmd.fill) begin
      c_vol_r <= c_vol_r - fill;
      n_r     <= n_r + CNT_W'(1);
    end
    out_r <= out_nxt;
  end

  assign sts.is_cancel = c_cancel_r == CMD_CANCEL;
  assign sts.add_done  = (c_vol_r == '0) || (n_r == CNT_W'(ORDER_SLOTS));
  assign sts.found     = found_r;
  assign sts.scan_last = idx_r == IDX_W'(ORDER_SLOTS - 1);
  assign sts.out_last  = out_r.last;
  assign out_item      = out_r;

endmodule

[src/order_book_matcher.sv]
// ----------------------------------------------------------------------------
// order_book_matcher
// Limit order book with price-time priority matching over a slot table.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_chan   sink       add or cancel command
//  out_chan  source     trade records, then one status record with last set
//
//  A cancel runs one best-order scan of the slots, one slot per cycle,
//  then gives its status. Each fill of an add follows its own scan; the final
//  status follows one more scan, or none when the add is already done.
//  Reset empties the book at once; no clearing pass.
//  A stalled output holds the controller in place; one command at a time.
// ----------------------------------------------------------------------------
module order_book_matcher #(
  parameter int ORDER_SLOTS = obm_pkg::ORDER_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  obm_in_if.sink    in_chan,
  obm_out_if.source out_chan
);
  import obm_pkg::*;

  obm_cmd_t      cmd;
  obm_sts_t      sts;
  obm_in_item_t  in_item;
  obm_out_item_t out_item;

  // Gather the input payload.
  assign in_item.cmd         = in_chan.cmd;
  assign in_item.order_ident = in_chan.order_ident;
  assign in_item.side        = in_chan.side;
  assign in_item.limit_price = in_chan.limit_price;
  assign in_item.quantity_in = in_chan.quantity_in;

  obm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  obm_dp #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // Drive the result payload.
  assign out_chan.kind           = out_item.kind;
  assign out_chan.buy_ident      = out_item.buy_ident;
  assign out_chan.sell_ident     = out_item.sell_ident;
  assign out_chan.trade_price    = out_item.trade_price;
  assign out_chan.trade_quantity = out_item.trade_quantity;
  assign out_chan.rested         = out_item.rested;
  assign out_chan.book_full      = out_item.book_full;
  assign out_chan.cancelled      = out_item.cancelled;
  assign out_chan.last           = out_item.last;

endmodule
